// ===== rtl/core/alpt_pkg.sv =====
`timescale 1ns / 1ps

package alpt_pkg;

   // Channel count and field widths
   localparam int CHANNELS  = 2;
   localparam int CH_W      = 1;
   localparam int SPEED_W   = 28;
   localparam int POS_W     = 48;
   localparam int WRAP_W    = 25;
   localparam int STEP_W    = 32;
   localparam int GAIN_W    = 24;
   localparam int CSR_IDX_W = 3;

   // Shared multiplier: signed A times unsigned 24-bit B
   localparam int MUL_A_W = 33;
   localparam int MUL_P_W = MUL_A_W + GAIN_W + 1;

   // Target accumulator: kp*error (up to 2^72) minus kd*step
   localparam int ACC_W = 75;

   // Full turn, 360 degrees in Q.16
   localparam logic [WRAP_W-1:0] FULL_TURN = 25'd23592960;

   // Register reset values
   localparam logic              ENABLE_RST = 1'b0;
   localparam logic [GAIN_W-1:0] TICK_RST   = 24'd16777;
   localparam logic [GAIN_W-1:0] ACCEL_RST  = 24'd200000;
   localparam logic [GAIN_W-1:0] KP_RST     = 24'd12800;
   localparam logic [GAIN_W-1:0] KD_RST     = 24'd2560000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENABLE      = 3'd0,
      REG_TICK_PERIOD = 3'd1,
      REG_ACCEL_LIMIT = 3'd2,
      REG_KP_GAIN     = 3'd3,
      REG_KD_GAIN     = 3'd4
   } csr_index_type;

endpackage

// ===== rtl/core/alpt_if.sv =====
`timescale 1ns / 1ps

interface alpt_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [alpt_pkg::CH_W-1:0]             channel;
   logic                                  tracking_mode;
   logic signed [alpt_pkg::SPEED_W-1:0]   speed_command;
   logic signed [alpt_pkg::POS_W-1:0]     position_goal;
   logic                                  clear_totals;

   modport source (output valid, channel, tracking_mode, speed_command,
                   position_goal, clear_totals, input ready);
   modport sink   (input valid, channel, tracking_mode, speed_command,
                   position_goal, clear_totals, output ready);
endinterface

interface alpt_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [alpt_pkg::CH_W-1:0]             out_channel;
   logic [alpt_pkg::WRAP_W-1:0]           wrapped_angle;
   logic signed [alpt_pkg::POS_W-1:0]     total_angle;
   logic signed [alpt_pkg::SPEED_W-1:0]   speed_now;
   logic signed [alpt_pkg::STEP_W-1:0]    step_angle;

   modport source (output valid, out_channel, wrapped_angle, total_angle,
                   speed_now, step_angle, input ready);
   modport sink   (input valid, out_channel, wrapped_angle, total_angle,
                   speed_now, step_angle, output ready);
endinterface

interface alpt_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [alpt_pkg::CSR_IDX_W-1:0]        index;
   logic [alpt_pkg::GAIN_W-1:0]           data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/alpt_mul.sv =====
`timescale 1ns / 1ps

module alpt_mul (
   input  logic                                 clock,
   input  logic signed [alpt_pkg::MUL_A_W-1:0]  a_in,
   input  logic [alpt_pkg::GAIN_W-1:0]          b_in,
   output logic signed [alpt_pkg::MUL_P_W-1:0]  prod
);

   logic signed [alpt_pkg::MUL_P_W-1:0] prod_ff;
   logic signed [alpt_pkg::MUL_P_W-1:0] prod_in;

   // B is unsigned: widen by a zero sign bit
   assign prod_in = a_in * $signed({1'b0, b_in});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/core/accel_limited_position_tracker_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake       Payload
// req_ch    in   valid/ready     channel, tracking_mode, speed_command,
//                                position_goal, clear_totals
// rsp_ch    out  valid/ready     out_channel, wrapped_angle, total_angle,
//                                speed_now, step_angle
// csr_ch    in   valid/ready     index (0 enable .. 4 kd_gain), data
//
// One tick at a time. Direct mode runs MUL_MAG, CALC_DV, MUL_STEP, CALC_STEP
// and ADD_POS, then WRAP when the angle wraps; tracking mode then adds MUL_KD
// to SET_TGT (kd*step, kp*err low/high). All products go through one registered
// 33x25 multiplier; the wrap is an 8-step compare-subtract by 360 deg shifted
// 7..0. Disabled ticks go straight to the result. A result holds on rsp_ch
// until its transfer; req_ch stays unready meanwhile. Synchronous reset clears
// all channel state and loads the register defaults. csr_ch is always ready.

module accel_limited_position_tracker_core (
   input  logic        clock,
   input  logic        reset,
   alpt_req_if.sink    req_ch,
   alpt_rsp_if.source  rsp_ch,
   alpt_csr_if.sink    csr_ch
);

   localparam int NCH = alpt_pkg::CHANNELS;
   localparam int SW  = alpt_pkg::SPEED_W;
   localparam int PW  = alpt_pkg::POS_W;
   localparam int WW  = alpt_pkg::WRAP_W;
   localparam int TW  = alpt_pkg::STEP_W;
   localparam int GW  = alpt_pkg::GAIN_W;
   localparam int AW  = alpt_pkg::MUL_A_W;
   localparam int MW  = alpt_pkg::MUL_P_W;
   localparam int CW  = alpt_pkg::ACC_W;
   localparam int VW  = 33;   // wrap remainder, holds up to 128 turns

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_MUL_MAG   = 13'b0000000000010,
      S_CALC_DV   = 13'b0000000000100,
      S_MUL_STEP  = 13'b0000000001000,
      S_CALC_STEP = 13'b0000000010000,
      S_ADD_POS   = 13'b0000000100000,
      S_WRAP      = 13'b0000001000000,
      S_MUL_KD    = 13'b0000010000000,
      S_ACC_KD    = 13'b0000100000000,
      S_ACC_KPL   = 13'b0001000000000,
      S_ACC_KPH   = 13'b0010000000000,
      S_SET_TGT   = 13'b0100000000000,
      S_RESULT    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration
   logic          enable_ff, enable_in;
   logic [GW-1:0] tick_ff, tick_in;
   logic [GW-1:0] accel_ff, accel_in;
   logic [GW-1:0] kp_ff, kp_in;
   logic [GW-1:0] kd_ff, kd_in;

   // Channel state
   logic signed [PW-1:0] total_ff  [NCH];
   logic signed [PW-1:0] total_in  [NCH];
   logic [WW-1:0]        wrapped_ff[NCH];
   logic [WW-1:0]        wrapped_in[NCH];
   logic signed [SW-1:0] speed_ff  [NCH];
   logic signed [SW-1:0] speed_in  [NCH];
   logic signed [SW-1:0] target_ff [NCH];
   logic signed [SW-1:0] target_in [NCH];

   // Per-tick working registers
   logic [alpt_pkg::CH_W-1:0] ch_ff, ch_in;
   logic                      track_ff, track_in;
   logic signed [PW-1:0]      goal_ff, goal_in;
   logic signed [SW:0]        dv_ff, dv_in;
   logic signed [TW-1:0]      step_ff, step_in;
   logic [VW-1:0]             wv_ff, wv_in;
   logic                      wpos_ff, wpos_in;
   logic [2:0]                bit_ff, bit_in;
   logic signed [PW:0]        err_ff, err_in;
   logic signed [CW-1:0]      acc_ff, acc_in;

   // Shared multiplier
   logic signed [AW-1:0] mul_a;
   logic [GW-1:0]        mul_b;
   logic signed [MW-1:0] mul_p;

   alpt_mul u_mul (
      .clock (clock),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .prod  (mul_p)
   );

   // Current channel view
   logic signed [SW-1:0] spd, tgt;
   logic signed [PW-1:0] tot;
   logic [WW-1:0]        wrp;

   assign spd = speed_ff[ch_ff];
   assign tgt = target_ff[ch_ff];
   assign tot = total_ff[ch_ff];
   assign wrp = wrapped_ff[ch_ff];

   // Datapath terms
   logic [MW-1:0]        mag_sum;
   logic signed [SW+1:0] mag, diff, ndiff, rate;
   logic signed [MW-1:0] step_sum;
   logic signed [MW-14:0] step_sh;
   logic signed [TW-1:0] step_sat;
   logic signed [PW:0]   tot_sum;
   logic signed [PW-1:0] tot_sat;
   logic signed [TW+1:0] wsum;
   logic                 w_neg, w_pos;
   logic [VW-1:0]        w_cmp, w_sub;
   logic signed [CW-21:0] tgt_sh;
   logic signed [SW-1:0] tgt_sat;

   always_comb begin
      // Speed change magnitude: round(accel*tick / 2^20)
      mag_sum = mul_p + MW'(1 << 19);
      mag     = $signed({1'b0, mag_sum[48:20]});
      diff    = $signed({{2{tgt[SW-1]}}, tgt}) - $signed({{2{spd[SW-1]}}, spd});
      ndiff   = -diff;
      rate    = $signed({spd[SW-1], spd, 1'b0}) + $signed({dv_ff[SW], dv_ff});

      // Step: floor((rate*tick + 2^12) / 2^13), saturate to 32 bits
      step_sum = mul_p + MW'(4096);
      step_sh  = step_sum[MW-1:13];
      if (step_sh[MW-14] && !(&step_sh[MW-15:TW-1])) begin
         step_sat = {1'b1, {(TW-1){1'b0}}};
      end else if (!step_sh[MW-14] && (|step_sh[MW-15:TW-1])) begin
         step_sat = {1'b0, {(TW-1){1'b1}}};
      end else begin
         step_sat = step_sh[TW-1:0];
      end

      // Total angle, saturate to 48 bits
      tot_sum = $signed({tot[PW-1], tot}) + (PW+1)'(step_ff);
      if (tot_sum[PW] != tot_sum[PW-1]) begin
         tot_sat = tot_sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
      end else begin
         tot_sat = tot_sum[PW-1:0];
      end

      // Wrapped angle before reduction
      wsum  = $signed({9'b0, wrp}) + (TW+2)'(step_ff);
      w_neg = wsum[TW+1];
      w_pos = wsum > $signed({9'b0, alpt_pkg::FULL_TURN});

      // One compare-subtract step of the wrap reduction
      w_cmp = VW'({8'b0, alpt_pkg::FULL_TURN}) << bit_ff;
      w_sub = (wv_ff >= w_cmp) ? (wv_ff - w_cmp) : wv_ff;

      // PD target: floor(acc / 2^20), saturate to 28 bits
      tgt_sh = acc_ff[CW-1:20];
      if (tgt_sh[CW-21] && !(&tgt_sh[CW-22:SW-1])) begin
         tgt_sat = {1'b1, {(SW-1){1'b0}}};
      end else if (!tgt_sh[CW-21] && (|tgt_sh[CW-22:SW-1])) begin
         tgt_sat = {1'b0, {(SW-1){1'b1}}};
      end else begin
         tgt_sat = tgt_sh[SW-1:0];
      end
   end

   // Sequencer and next-state values
   always_comb begin
      state_in  = state_ff;
      enable_in = enable_ff;
      tick_in   = tick_ff;
      accel_in  = accel_ff;
      kp_in     = kp_ff;
      kd_in     = kd_ff;
      total_in   = total_ff;
      wrapped_in = wrapped_ff;
      speed_in   = speed_ff;
      target_in  = target_ff;
      ch_in    = ch_ff;
      track_in = track_ff;
      goal_in  = goal_ff;
      dv_in    = dv_ff;
      step_in  = step_ff;
      wv_in    = wv_ff;
      wpos_in  = wpos_ff;
      bit_in   = bit_ff;
      err_in   = err_ff;
      acc_in   = acc_ff;
      mul_a    = '0;
      mul_b    = '0;

      // Register writes
      if (csr_ch.valid) begin
         case (csr_ch.index)
            alpt_pkg::REG_ENABLE:      enable_in = csr_ch.data[0];
            alpt_pkg::REG_TICK_PERIOD: tick_in   = csr_ch.data;
            alpt_pkg::REG_ACCEL_LIMIT: accel_in  = csr_ch.data;
            alpt_pkg::REG_KP_GAIN:     kp_in     = csr_ch.data;
            alpt_pkg::REG_KD_GAIN:     kd_in     = csr_ch.data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               ch_in    = req_ch.channel;
               track_in = req_ch.tracking_mode;
               goal_in  = req_ch.position_goal;
               step_in  = '0;
               if (enable_ff) begin
                  // Clear totals and load the direct target before the step
                  if (req_ch.clear_totals) begin
                     for (int i = 0; i < NCH; i++) begin
                        total_in[i] = '0;
                     end
                  end
                  if (!req_ch.tracking_mode) begin
                     target_in[req_ch.channel] = req_ch.speed_command;
                  end
                  state_in = S_MUL_MAG;
               end else begin
                  state_in = S_RESULT;
               end
            end
         end
         S_MUL_MAG: begin
            mul_a    = $signed({9'b0, accel_ff});
            mul_b    = tick_ff;
            state_in = S_CALC_DV;
         end
         S_CALC_DV: begin
            // Move toward target by at most mag, land exactly on it
            if (diff > 0) begin
               dv_in = (mag < diff) ? mag[SW:0] : diff[SW:0];
            end else if (diff < 0) begin
               dv_in = (mag < ndiff) ? -mag[SW:0] : diff[SW:0];
            end else begin
               dv_in = '0;
            end
            state_in = S_MUL_STEP;
         end
         S_MUL_STEP: begin
            mul_a    = AW'(rate);
            mul_b    = tick_ff;
            state_in = S_CALC_STEP;
         end
         S_CALC_STEP: begin
            step_in         = step_sat;
            speed_in[ch_ff] = spd + dv_ff[SW-1:0];
            state_in        = S_ADD_POS;
         end
         S_ADD_POS: begin
            total_in[ch_ff] = tot_sat;
            wpos_in         = w_pos;
            if (w_neg || w_pos) begin
               // Negative sums are lifted by 128 turns so one path reduces both
               wv_in    = w_neg ? VW'(wsum + (TW+2)'({alpt_pkg::FULL_TURN, 7'b0}))
                                : VW'(wsum);
               bit_in   = 3'd7;
               state_in = S_WRAP;
            end else begin
               wrapped_in[ch_ff] = wsum[WW-1:0];
               state_in          = track_ff ? S_MUL_KD : S_RESULT;
            end
         end
         S_WRAP: begin
            wv_in  = w_sub;
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               // A positive overflow that lands on zero keeps a full turn
               wrapped_in[ch_ff] = (wpos_ff && (w_sub == '0)) ? alpt_pkg::FULL_TURN
                                                              : w_sub[WW-1:0];
               state_in          = track_ff ? S_MUL_KD : S_RESULT;
            end
         end
         S_MUL_KD: begin
            mul_a    = AW'(step_ff);
            mul_b    = kd_ff;
            err_in   = $signed({goal_ff[PW-1], goal_ff}) - $signed({tot[PW-1], tot});
            state_in = S_ACC_KD;
         end
         S_ACC_KD: begin
            acc_in   = CW'(1 << 19) - CW'(mul_p);
            mul_a    = $signed({9'b0, err_ff[23:0]});
            mul_b    = kp_ff;
            state_in = S_ACC_KPL;
         end
         S_ACC_KPL: begin
            // Upper error half is signed: extend its sign into the operand
            acc_in   = acc_ff + CW'(mul_p);
            mul_a    = AW'($signed(err_ff[PW:24]));
            mul_b    = kp_ff;
            state_in = S_ACC_KPH;
         end
         S_ACC_KPH: begin
            acc_in   = acc_ff + (CW'(mul_p) <<< 24);
            state_in = S_SET_TGT;
         end
         S_SET_TGT: begin
            target_in[ch_ff] = tgt_sat;
            state_in         = S_RESULT;
         end
         S_RESULT: begin
            // Hold the result until its transfer
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         enable_ff <= alpt_pkg::ENABLE_RST;
         tick_ff   <= alpt_pkg::TICK_RST;
         accel_ff  <= alpt_pkg::ACCEL_RST;
         kp_ff     <= alpt_pkg::KP_RST;
         kd_ff     <= alpt_pkg::KD_RST;
         for (int i = 0; i < NCH; i++) begin
            total_ff[i]   <= '0;
            wrapped_ff[i] <= '0;
            speed_ff[i]   <= '0;
            target_ff[i]  <= '0;
         end
      end else begin
         state_ff   <= state_in;
         enable_ff  <= enable_in;
         tick_ff    <= tick_in;
         accel_ff   <= accel_in;
         kp_ff      <= kp_in;
         kd_ff      <= kd_in;
         total_ff   <= total_in;
         wrapped_ff <= wrapped_in;
         speed_ff   <= speed_in;
         target_ff  <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff    <= ch_in;
      track_ff <= track_in;
      goal_ff  <= goal_in;
      dv_ff    <= dv_in;
      step_ff  <= step_in;
      wv_ff    <= wv_in;
      wpos_ff  <= wpos_in;
      bit_ff   <= bit_in;
      err_ff   <= err_in;
      acc_ff   <= acc_in;
   end

   // Ports
   assign req_ch.ready         = (state_ff == S_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = (state_ff == S_RESULT);
   assign rsp_ch.out_channel   = ch_ff;
   assign rsp_ch.wrapped_angle = wrp;
   assign rsp_ch.total_angle   = tot;
   assign rsp_ch.speed_now     = spd;
   assign rsp_ch.step_angle    = step_ff;

endmodule

// ===== rtl/core/alpt_checker.sv =====
`timescale 1ns / 1ps

module alpt_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [alpt_pkg::WRAP_W-1:0]  wrapped_angle
);

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // No new tick is taken while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while result pending");

   // A transfer on the input closes the input for the tick's work
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a transfer");

   // Wrapped angle never leaves 0..360 degrees
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> wrapped_angle <= alpt_pkg::FULL_TURN)
      else $error("wrapped angle beyond a full turn");

endmodule

bind accel_limited_position_tracker_core alpt_checker u_alpt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .wrapped_angle (rsp_ch.wrapped_angle)
);
